// ===== src/sha256_byte_hasher_assert.svh =====
// ---------------------------------------------------------------------------
// SHA-256 byte hasher assertion macros
// Shorthand for clocked assertions, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef SHA256_BYTE_HASHER_ASSERT_SVH
`define SHA256_BYTE_HASHER_ASSERT_SVH

// expr holds at every edge
`define SHABH_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// ante at one edge implies cons at the next
`define SHABH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/sha256bh_pkg.sv =====
// ---------------------------------------------------------------------------
// SHA-256 byte hasher package
// Shared types, round constants and SHA-256 bit functions.
// ---------------------------------------------------------------------------
package sha256bh_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BLOCK_W  = 512;
  localparam int unsigned ROUNDS   = 64;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0] POS_LAST      = 6'd63;
  localparam logic [5:0] POS_LEN       = 6'd56;
  localparam logic [5:0] ROUND_LAST    = 6'd63;
  localparam logic [2:0] WORD_LAST     = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FINAL,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN
  } pad_sel_t;

  typedef struct packed {
    logic       load_msg;
    logic       load_pad;
    pad_sel_t   pad_sel;
    logic       init_work;
    logic       round_en;
    logic [5:0] round_idx;
    logic       chain_add;
    logic [2:0] word_idx;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;
  } status_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] t);
    unique case (t)
      6'd0:  round_const = 32'h428a2f98;
      6'd1:  round_const = 32'h71374491;
      6'd2:  round_const = 32'hb5c0fbcf;
      6'd3:  round_const = 32'he9b5dba5;
      6'd4:  round_const = 32'h3956c25b;
      6'd5:  round_const = 32'h59f111f1;
      6'd6:  round_const = 32'h923f82a4;
      6'd7:  round_const = 32'hab1c5ed5;
      6'd8:  round_const = 32'hd807aa98;
      6'd9:  round_const = 32'h12835b01;
      6'd10: round_const = 32'h243185be;
      6'd11: round_const = 32'h550c7dc3;
      6'd12: round_const = 32'h72be5d74;
      6'd13: round_const = 32'h80deb1fe;
      6'd14: round_const = 32'h9bdc06a7;
      6'd15: round_const = 32'hc19bf174;
      6'd16: round_const = 32'he49b69c1;
      6'd17: round_const = 32'hefbe4786;
      6'd18: round_const = 32'h0fc19dc6;
      6'd19: round_const = 32'h240ca1cc;
      6'd20: round_const = 32'h2de92c6f;
      6'd21: round_const = 32'h4a7484aa;
      6'd22: round_const = 32'h5cb0a9dc;
      6'd23: round_const = 32'h76f988da;
      6'd24: round_const = 32'h983e5152;
      6'd25: round_const = 32'ha831c66d;
      6'd26: round_const = 32'hb00327c8;
      6'd27: round_const = 32'hbf597fc7;
      6'd28: round_const = 32'hc6e00bf3;
      6'd29: round_const = 32'hd5a79147;
      6'd30: round_const = 32'h06ca6351;
      6'd31: round_const = 32'h14292967;
      6'd32: round_const = 32'h27b70a85;
      6'd33: round_const = 32'h2e1b2138;
      6'd34: round_const = 32'h4d2c6dfc;
      6'd35: round_const = 32'h53380d13;
      6'd36: round_const = 32'h650a7354;
      6'd37: round_const = 32'h766a0abb;
      6'd38: round_const = 32'h81c2c92e;
      6'd39: round_const = 32'h92722c85;
      6'd40: round_const = 32'ha2bfe8a1;
      6'd41: round_const = 32'ha81a664b;
      6'd42: round_const = 32'hc24b8b70;
      6'd43: round_const = 32'hc76c51a3;
      6'd44: round_const = 32'hd192e819;
      6'd45: round_const = 32'hd6990624;
      6'd46: round_const = 32'hf40e3585;
      6'd47: round_const = 32'h106aa070;
      6'd48: round_const = 32'h19a4c116;
      6'd49: round_const = 32'h1e376c08;
      6'd50: round_const = 32'h2748774c;
      6'd51: round_const = 32'h34b0bcb5;
      6'd52: round_const = 32'h391c0cb3;
      6'd53: round_const = 32'h4ed8aa4a;
      6'd54: round_const = 32'h5b9cca4f;
      6'd55: round_const = 32'h682e6ff3;
      6'd56: round_const = 32'h748f82ee;
      6'd57: round_const = 32'h78a5636f;
      6'd58: round_const = 32'h84c87814;
      6'd59: round_const = 32'h8cc70208;
      6'd60: round_const = 32'h90befffa;
      6'd61: round_const = 32'ha4506ceb;
      6'd62: round_const = 32'hbef9a3f7;
      6'd63: round_const = 32'hc67178f2;
      default: round_const = 32'h0;
    endcase
  endfunction

endpackage

// ===== src/sha256bh_ctrl.sv =====
// ---------------------------------------------------------------------------
// SHA-256 byte hasher controller
// Sequences byte loads, padding, compression rounds and digest output.
// ---------------------------------------------------------------------------
module sha256bh_ctrl
  import sha256bh_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_present,
  input  logic    in_end,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    out_last,
  input  status_t status,
  output cmd_t    cmd
);

  state_t     state;
  state_t     state_next;
  logic [5:0] round;
  logic [2:0] word;
  logic       end_pend;   // message end seen, digest not yet delivered
  logic       pad_first;  // next pad byte is the 0x80 marker
  logic       len_block;  // current block carries the length
  logic       len_done;   // length written, last compression or digest output under way
  logic       accept;
  logic       pos_last;

  assign accept   = in_valid && (state == S_IDLE);
  assign pos_last = (status.pos == POS_LAST);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && in_present && pos_last) begin
          state_next = S_ROUND;
        end else if (accept && in_end) begin
          state_next = S_PAD;
        end
      end
      S_PAD: begin
        if (pos_last) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        if (round == ROUND_LAST) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        if (len_done) begin
          state_next = S_OUT;
        end else if (end_pend) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready && (word == WORD_LAST)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    out_valid     = (state == S_OUT);
    out_last      = (word == WORD_LAST);
    cmd.load_msg  = accept && in_present;
    cmd.load_pad  = (state == S_PAD);
    priority if (pad_first) begin
      cmd.pad_sel = PAD_MARK;
    end else if (len_block && (status.pos >= POS_LEN)) begin
      cmd.pad_sel = PAD_LEN;
    end else begin
      cmd.pad_sel = PAD_ZERO;
    end
    cmd.init_work = (cmd.load_msg || cmd.load_pad) && pos_last;
    cmd.round_en  = (state == S_ROUND);
    cmd.round_idx = round;
    cmd.chain_add = (state == S_FINAL);
    cmd.word_idx  = word;
    cmd.finish    = (state == S_OUT) && out_ready && (word == WORD_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      round     <= '0;
      word      <= '0;
      end_pend  <= 1'b0;
      pad_first <= 1'b0;
      len_block <= 1'b0;
      len_done  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_ROUND) begin
        round <= round + 6'd1;
      end
      if ((state == S_OUT) && out_ready) begin
        word <= word + 3'd1;
      end
      if (accept && in_end) begin
        end_pend  <= 1'b1;
        pad_first <= 1'b1;
      end
      if (state == S_PAD) begin
        pad_first <= 1'b0;
        // marker early enough for the length, or spill into a fresh block
        if ((pad_first && (status.pos < POS_LEN)) || pos_last) begin
          len_block <= 1'b1;
        end
        if (pos_last && len_block) begin
          len_done <= 1'b1;
        end
      end
      if (cmd.finish) begin
        end_pend  <= 1'b0;
        len_block <= 1'b0;
        len_done  <= 1'b0;
      end
    end
  end

endmodule

// ===== src/sha256bh_dp.sv =====
// ---------------------------------------------------------------------------
// SHA-256 byte hasher datapath
// Message window, round unit, chain value and bit counter.
// ---------------------------------------------------------------------------
module sha256bh_dp
  import sha256bh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  cmd_t        cmd,
  output status_t     status,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index
);

  logic [BLOCK_W-1:0] window;     // 16 words, word 0 in the top bits
  logic [31:0]        chain [8];
  logic [63:0]        message_bits;
  logic [5:0]         pos;
  logic [31:0]        wa, wb, wc, wd, we, wf, wg, wh;

  logic [7:0][7:0]    len_view;
  logic [7:0]         pad_byte;
  logic [7:0]         byte_in;
  logic               load;
  logic [31:0]        w0, w1, w9, w14;
  logic [31:0]        w_new;
  logic [31:0]        w_t;
  logic [31:0]        t1;
  logic [31:0]        t2;

  assign len_view = message_bits;
  assign load     = cmd.load_msg || cmd.load_pad;

  always_comb begin
    unique case (cmd.pad_sel)
      PAD_MARK: pad_byte = PAD_MARK_BYTE;
      PAD_LEN:  pad_byte = len_view[~pos[2:0]];   // big-endian length
      default:  pad_byte = 8'h00;
    endcase
    byte_in = cmd.load_msg ? data_byte : pad_byte;
  end

  assign w0  = window[BLOCK_W-1 -: WORD_W];
  assign w1  = window[BLOCK_W-1-WORD_W -: WORD_W];
  assign w9  = window[BLOCK_W-1-9*WORD_W -: WORD_W];
  assign w14 = window[BLOCK_W-1-14*WORD_W -: WORD_W];

  always_comb begin
    w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
    // first 16 rounds just rotate the loaded words through
    w_t   = (cmd.round_idx[5:4] == 2'b00) ? w0 : w_new;
    t1    = wh + big_sigma1(we) + ((we & wf) ^ (~we & wg)) + round_const(cmd.round_idx) + w_t;
    t2    = big_sigma0(wa) + ((wa & wb) ^ (wa & wc) ^ (wb & wc));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      message_bits <= '0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= SHA_IV[i];
      end
    end else begin
      if (load) begin
        pos <= pos + 6'd1;
      end
      if (cmd.finish) begin
        message_bits <= '0;
      end else if (cmd.load_msg) begin
        message_bits <= message_bits + 64'd8;
      end
      if (cmd.finish) begin
        for (int i = 0; i < 8; i++) begin
          chain[i] <= SHA_IV[i];
        end
      end else if (cmd.chain_add) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
        chain[4] <= chain[4] + we;
        chain[5] <= chain[5] + wf;
        chain[6] <= chain[6] + wg;
        chain[7] <= chain[7] + wh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      window <= {window[BLOCK_W-9:0], byte_in};
    end else if (cmd.round_en) begin
      window <= {window[BLOCK_W-WORD_W-1:0], w_t};
    end
    if (cmd.init_work) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
      we <= chain[4];
      wf <= chain[5];
      wg <= chain[6];
      wh <= chain[7];
    end else if (cmd.round_en) begin
      wh <= wg;
      wg <= wf;
      wf <= we;
      we <= wd + t1;
      wd <= wc;
      wc <= wb;
      wb <= wa;
      wa <= t1 + t2;
    end
  end

  assign status.pos  = pos;
  assign digest_word = chain[cmd.word_idx];
  assign word_index  = cmd.word_idx;

endmodule

// ===== src/sha256_byte_hasher.sv =====
// ---------------------------------------------------------------------------
// SHA-256 byte hasher
// Hashes a byte stream and returns the eight digest words per message.
// ---------------------------------------------------------------------------
// One request in, one byte (optional) and an end flag. The byte that fills
// a 64-byte block starts 64 rounds of the single round unit, then the chain
// add; no new byte is taken until they are done. On end of message the pad
// bytes go through the same byte path, one per cycle, followed by one or two
// compressions, then the eight digest words are offered one per cycle while
// the receiver is ready, first word first. No input is taken while a
// compression, padding or digest output is in progress.
module sha256_byte_hasher
  import sha256bh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast    // last_word
);

  cmd_t        cmd;
  status_t     status;
  logic [31:0] digest_word;
  logic [2:0]  word_index;

  sha256bh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_present (s_axis_tuser),
    .in_end     (s_axis_tlast),
    .in_ready   (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_last   (m_axis_tlast),
    .status     (status),
    .cmd        (cmd)
  );

  sha256bh_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (s_axis_tdata),
    .cmd         (cmd),
    .status      (status),
    .digest_word (digest_word),
    .word_index  (word_index)
  );

  assign m_axis_tdata = {5'b0, word_index, digest_word};

endmodule

// ===== src/sha256bh_checker.sv =====
// ---------------------------------------------------------------------------
// SHA-256 byte hasher port checker
// Watches the top-level ports of the hasher over time.
// ---------------------------------------------------------------------------
`include "sha256_byte_hasher_assert.svh"

module sha256bh_checker
  import sha256bh_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic        out_fire;
  logic        out_stall;
  logic        more_words;
  logic        last_fire;
  logic        last_ok;
  logic [2:0]  out_index;
  logic [2:0]  idx_next;

  assign out_fire   = m_axis_tvalid && m_axis_tready;
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign more_words = out_fire && !m_axis_tlast;
  assign last_fire  = out_fire && m_axis_tlast;
  assign out_index  = m_axis_tdata[34:32];
  assign idx_next   = out_index + 3'd1;
  assign last_ok    = (m_axis_tlast == (out_index == WORD_LAST));

  // input side stays closed while a digest is being delivered
  `SHABH_ASSERT_ALWAYS(a_no_overlap, !(s_axis_tready && m_axis_tvalid), "ready during output")
  `SHABH_ASSERT_ALWAYS(a_last_at_seven, !m_axis_tvalid || last_ok, "tlast misplaced")
  `SHABH_ASSERT_NEXT(a_idx_step, more_words, m_axis_tvalid && out_index == $past(idx_next), "index gap")
  `SHABH_ASSERT_NEXT(a_ready_after_last, last_fire, s_axis_tready, "not ready after digest")
  `SHABH_ASSERT_NEXT(a_hold_stall, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "output changed")

endmodule

bind sha256_byte_hasher sha256bh_checker u_checker (.*);
